/* hdl/glb_pkg.sv */
// Shared types, register codes and pixel expansion for the glyph bitmap unpacker.
`default_nettype none

package glb_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_STRIDE = 2'd3;

    // Pixel depth codes
    localparam logic [1:0] MODE_1BPP = 2'd0;
    localparam logic [1:0] MODE_2BPP = 2'd1;
    localparam logic [1:0] MODE_4BPP = 2'd2;
    localparam logic [1:0] MODE_8BPP = 2'd3;

    localparam logic [1:0] DEPTH_RESET = MODE_4BPP;

    // 2bpp opacity levels
    localparam logic [7:0] OPACITY_2BPP [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

    typedef struct packed {
        logic [1:0] depth;
        logic [7:0] width;
        logic [7:0] height;
        logic [7:0] stride;
    } cfg_t;

    typedef struct packed {
        logic [7:0] opacity;
        logic [7:0] column;
        logic [7:0] row;
        logic       last_of_byte;
        logic       glyph_end;
    } pixel_t;

    // Expand the pixel sitting in the top bits of the working byte
    function automatic logic [7:0] expand_opacity(input logic [7:0] msb_bits,
                                                  input logic [1:0] mode);
        logic [7:0] result;
        result = msb_bits;
        case (mode)
            MODE_1BPP: result = msb_bits[7] ? 8'hFF : 8'h00;
            MODE_2BPP: result = OPACITY_2BPP[msb_bits[7:6]];
            MODE_4BPP: result = {msb_bits[7:4], msb_bits[7:4]};
            default:   result = msb_bits;
        endcase
        return result;
    endfunction

    // Index of the last pixel slot in a byte
    function automatic logic [2:0] last_slot(input logic [1:0] mode);
        logic [2:0] result;
        result = 3'd0;
        case (mode)
            MODE_1BPP: result = 3'd7;
            MODE_2BPP: result = 3'd3;
            MODE_4BPP: result = 3'd1;
            default:   result = 3'd0;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

/* hdl/glb_byte_if.sv */
// Input channel carrying packed bitmap words.
`default_nettype none

interface glb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       glyph_start;

    modport source (output valid, output packed_byte, output glyph_start, input ready);
    modport sink   (input valid, input packed_byte, input glyph_start, output ready);
endinterface

`default_nettype wire

/* hdl/glb_pixel_if.sv */
// Output channel carrying expanded pixel words.
`default_nettype none

interface glb_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_opacity;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic       last_of_byte;
    logic       glyph_end;

    modport source (output valid, output pixel_opacity, output pixel_column,
                    output pixel_row, output last_of_byte, output glyph_end,
                    input ready);
    modport sink   (input valid, input pixel_opacity, input pixel_column,
                    input pixel_row, input last_of_byte, input glyph_end,
                    output ready);
endinterface

`default_nettype wire

/* hdl/glb_cfg_regs.sv */
// Configuration register file for the glyph bitmap unpacker.
`default_nettype none

module glb_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data,
    output glb_pkg::cfg_t       cfg
);

    glb_pkg::cfg_t cfg_reg;

    // Decode and hold register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth  <= glb_pkg::DEPTH_RESET;
            cfg_reg.width  <= 8'd0;
            cfg_reg.height <= 8'd0;
            cfg_reg.stride <= 8'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                glb_pkg::REG_DEPTH:  cfg_reg.depth  <= cfg_data[1:0];
                glb_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_data;
                glb_pkg::REG_HEIGHT: cfg_reg.height <= cfg_data;
                glb_pkg::REG_STRIDE: cfg_reg.stride <= cfg_data;
                default:             cfg_reg.stride <= cfg_reg.stride;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/glb_unpack_engine.sv */
// Byte holding register and per-pixel unpack step with glyph position tracking.
`default_nettype none

module glb_unpack_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  glb_pkg::cfg_t       cfg,
    glb_byte_if.sink            in_ch,
    input  wire logic           out_free,
    output logic                pix_load,
    output glb_pkg::pixel_t     pix
);

    // Byte under work
    logic       busy_reg;
    logic [7:0] work_reg;
    logic       start_reg;
    logic [2:0] slot_reg;

    // Glyph position state
    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic [7:0] taken_reg;
    logic       fin_reg;

    logic [7:0] col_next;
    logic [7:0] row_next;
    logic [7:0] taken_next;
    logic       fin_next;

    logic       first;
    logic       stride_on;
    logic [7:0] c0, r0, t0;
    logic       f0;
    logic       skip;
    logic [7:0] c1, r1;
    logic       row_out;
    logic       emit;
    logic       end_px;
    logic [7:0] c2, r2;
    logic       done;
    logic [10:0] need_bits;
    logic [7:0] need_bytes;
    logic [7:0] limit;
    logic [8:0] taken_inc;
    logic [7:0] r3;
    logic       advance;
    logic       accept;

    assign first     = (slot_reg == 3'd0);
    assign stride_on = (cfg.stride != 8'd0);

    // Bytes per row: the stride, or more if the pixels need more
    assign need_bits  = {3'b000, cfg.width} << cfg.depth;
    assign need_bytes = need_bits[10:3] + {7'd0, (need_bits[2:0] != 3'd0)};
    assign limit      = (cfg.stride > need_bytes) ? cfg.stride : need_bytes;

    // Compute one step of the current byte
    always_comb
    begin
        // glyph restart before the first pixel
        if (first && start_reg)
        begin
            c0 = 8'd0;
            r0 = 8'd0;
            t0 = 8'd0;
            f0 = 1'b0;
        end
        else
        begin
            c0 = col_reg;
            r0 = row_reg;
            t0 = taken_reg;
            f0 = fin_reg;
        end

        skip = first && (f0 || cfg.width == 8'd0 || cfg.height == 8'd0);

        // wrap a full row in continuous mode
        c1 = c0;
        r1 = r0;
        if (first && !skip && !stride_on && c0 >= cfg.width)
        begin
            c1 = 8'd0;
            r1 = 8'(r0 + 8'd1);
        end

        row_out = first && !skip && (r1 >= cfg.height);
        emit    = !skip && !row_out && (c1 < cfg.width);
        end_px  = emit && ({1'b0, r1} + 9'd1 == {1'b0, cfg.height})
                       && ({1'b0, c1} + 9'd1 == {1'b0, cfg.width});

        // advance position past the emitted pixel
        c2 = emit ? 8'(c1 + 8'd1) : c1;
        r2 = r1;
        if (emit && !end_px && !stride_on && c2 >= cfg.width)
        begin
            c2 = 8'd0;
            r2 = 8'(r1 + 8'd1);
        end

        done = skip || row_out || !emit || end_px
            || (slot_reg == glb_pkg::last_slot(cfg.depth))
            || (stride_on && c2 >= cfg.width);

        col_next   = c2;
        row_next   = r2;
        taken_next = t0;
        fin_next   = f0 || row_out || end_px;
        taken_inc  = {1'b0, t0} + 9'd1;
        r3         = 8'(r2 + 8'd1);

        // row accounting at the end of a byte in strided mode
        if (done && !skip && !row_out && stride_on && !fin_next)
        begin
            if (taken_inc >= {1'b0, limit})
            begin
                taken_next = 8'd0;
                col_next   = 8'd0;
                row_next   = r3;
                fin_next   = (r3 >= cfg.height);
            end
            else
            begin
                taken_next = taken_inc[7:0];
            end
        end
    end

    assign advance     = busy_reg && (!emit || out_free);
    assign in_ch.ready = !busy_reg || (advance && done);
    assign accept      = in_ch.valid && in_ch.ready;

    assign pix_load         = advance && emit;
    assign pix.opacity      = glb_pkg::expand_opacity(work_reg, cfg.depth);
    assign pix.column       = c1;
    assign pix.row          = r1;
    assign pix.last_of_byte = done;
    assign pix.glyph_end    = end_px;

    // Hold the byte under work and step through its pixel slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
            slot_reg  <= 3'd0;
            col_reg   <= 8'd0;
            row_reg   <= 8'd0;
            taken_reg <= 8'd0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                taken_reg <= taken_next;
                fin_reg   <= fin_next;
                slot_reg  <= 3'(slot_reg + 3'd1);
                if (done)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                busy_reg  <= 1'b1;
                start_reg <= in_ch.glyph_start;
                slot_reg  <= 3'd0;
            end
        end
    end

    // Shift the next pixel into the top bits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= in_ch.packed_byte;
        end
        else if (pix_load)
        begin
            work_reg <= work_reg << (4'd1 << cfg.depth);
        end
    end

endmodule

`default_nettype wire

/* hdl/glb_out_stage.sv */
// Output register for expanded pixel words.
`default_nettype none

module glb_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pix_load,
    input  glb_pkg::pixel_t     pix,
    output logic                out_free,
    glb_pixel_if.source         out_ch
);

    logic            valid_reg;
    glb_pkg::pixel_t pix_reg;

    assign out_free = !valid_reg || out_ch.ready;

    // Hold a word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_load)
        begin
            pix_reg <= pix;
        end
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.pixel_opacity = pix_reg.opacity;
    assign out_ch.pixel_column  = pix_reg.column;
    assign out_ch.pixel_row     = pix_reg.row;
    assign out_ch.last_of_byte  = pix_reg.last_of_byte;
    assign out_ch.glyph_end     = pix_reg.glyph_end;

endmodule

`default_nettype wire

/* hdl/glyph_bitmap_unpack_core.sv */
// Top level of the glyph bitmap unpacker: packed bitmap words in, opacity pixel words out.
//
// packed_data takes one packed bitmap byte per word; glyph_start on a word restarts the
// glyph at column 0, row 0. pixel_data gives one pixel per word with its opacity, column,
// row, a last-of-byte mark and a glyph-end mark. Configuration (depth, width, height,
// row stride) is written through cfg_write/cfg_index/cfg_data. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Throughput: up to one pixel per cycle while the receiver takes words; a byte holds 8 pixel
// slots at 1bpp, 4 at 2bpp, 2 at 4bpp and 1 at 8bpp, stepped by glb_unpack_engine.
// Each pixel is expanded from the byte register and held in the output register before it
// appears on pixel_data; the further pixels of a byte follow in slot order.
// The byte register takes the next word in the same cycle the last pixel of the current
// byte moves to the output register. When the receiver stalls, the output register holds
// its word, the engine waits, and packed_data is held off once a byte is under work.
// Reset clears position state (the first glyph starts at the origin) and sets the
// registers to 4bpp, zero width, height and stride.
`default_nettype none

module glyph_bitmap_unpack_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    glb_byte_if.sink        packed_data,
    glb_pixel_if.source     pixel_data
);

    glb_pkg::cfg_t   cfg;
    glb_pkg::pixel_t pix;
    logic            pix_load;
    logic            out_free;

    glb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    glb_unpack_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (packed_data),
        .out_free (out_free),
        .pix_load (pix_load),
        .pix      (pix)
    );

    glb_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_load (pix_load),
        .pix      (pix),
        .out_free (out_free),
        .out_ch   (pixel_data)
    );

endmodule

`default_nettype wire
